// ===== rtl/ptw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_pkg
// Types, codes and helpers shared by the four-level page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

  localparam int PTW_STORE_WORDS = 4096;

  // Word address of an entry: 40 frame bits above a 9-bit index.
  localparam int WORD_W  = 49;
  localparam int FRAME_W = 40;
  localparam int VA_W    = 48;
  localparam int PA_W    = 52;
  localparam int PTE_W   = 64;
  localparam int IDX_W   = 12;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_XLATE = 1'b1;

  localparam logic [2:0] REG_ROOT_ADDR = 3'd0;

  typedef enum logic [2:0] {
    ST_OK  = 3'd0,
    ST_NP4 = 3'd1,
    ST_NP3 = 3'd2,
    ST_NP2 = 3'd3,
    ST_NP1 = 3'd4,
    ST_BIG = 3'd5,
    ST_OUT = 3'd6
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  // Table index for a level; lvl 3 is the top table, lvl 0 the last.
  function automatic logic [8:0] idx_sel(input logic [VA_W-1:0] va, input logic [1:0] lvl);
    logic [8:0] idx;
    case (lvl)
      2'd3:    idx = va[47:39];
      2'd2:    idx = va[38:30];
      2'd1:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

  function automatic status_t not_present(input logic [1:0] lvl);
    status_t st;
    case (lvl)
      2'd3:    st = ST_NP4;
      2'd2:    st = ST_NP3;
      2'd1:    st = ST_NP2;
      default: st = ST_NP1;
    endcase
    return st;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ptw_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_ram
// Single-port RAM: reads every cycle, writes when we; registered read data.
// ----------------------------------------------------------------------------
module ptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== rtl/ptw_walk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_walk
// Table store and walk sequencer: one RAM read per level, evaluated as the
// data returns while the next level's read is issued.
// ----------------------------------------------------------------------------
module ptw_walk
  import ptw_pkg::*;
#(
  parameter int STORE_WORDS = PTW_STORE_WORDS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               mode,
  input  wire logic [IDX_W-1:0]   word_index,
  input  wire logic [PTE_W-1:0]   entry_value,
  input  wire logic [VA_W-1:0]    virtual_address,
  input  wire logic [FRAME_W-1:0] root_frame,
  output logic                    busy,
  output logic                    done,
  output logic [2:0]              status,
  output logic [PA_W-1:0]         physical_address
);

  localparam int AW = $clog2(STORE_WORDS);
  localparam logic [WORD_W-1:0] LIMIT = WORD_W'(STORE_WORDS);

  state_t            state, state_next;
  logic [1:0]        lvl, lvl_next;
  logic [VA_W-1:0]   va;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [PTE_W-1:0]  ram_rdata;
  logic [WORD_W-1:0] wr_word, root_word, nxt_word;
  logic              fin;
  status_t           fin_status;
  logic [PA_W-1:0]   fin_pa;
  logic              res_valid;
  status_t           res_status;
  logic [PA_W-1:0]   res_pa;

  ptw_ram #(
    .WIDTH (PTE_W),
    .DEPTH (STORE_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (entry_value),
    .rdata (ram_rdata)
  );

  assign wr_word   = WORD_W'(word_index);
  assign root_word = {root_frame, virtual_address[47:39]};
  assign nxt_word  = {ram_rdata[51:12], idx_sel(va, 2'(lvl - 2'd1))};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lvl       <= 2'd3;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      lvl       <= lvl_next;
      res_valid <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start && mode == MODE_XLATE) begin
      va <= virtual_address;
    end
    if (fin) begin
      res_status <= fin_status;
      res_pa     <= fin_pa;
    end
  end

  always_comb begin
    state_next = state;
    lvl_next   = lvl;
    ram_we     = 1'b0;
    ram_addr   = root_word[AW-1:0];
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_pa     = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (mode == MODE_WRITE) begin
            // drop writes beyond the store
            ram_we   = (wr_word < LIMIT);
            ram_addr = wr_word[AW-1:0];
          end else if (root_word >= LIMIT) begin
            fin        = 1'b1;
            fin_status = ST_OUT;
          end else begin
            state_next = S_READ;
            lvl_next   = 2'd3;
          end
        end
      end
      S_READ: begin
        ram_addr = nxt_word[AW-1:0];
        if (!ram_rdata[0]) begin
          fin        = 1'b1;
          fin_status = not_present(lvl);
        end else if (lvl == 2'd2 && ram_rdata[7]) begin
          fin        = 1'b1;
          fin_status = ST_BIG;
        end else if (lvl == 2'd1 && ram_rdata[7]) begin
          fin    = 1'b1;
          fin_pa = {ram_rdata[51:21], va[20:0]};
        end else if (lvl == 2'd0) begin
          fin    = 1'b1;
          fin_pa = {ram_rdata[51:12], va[11:0]};
        end else if (nxt_word >= LIMIT) begin
          fin        = 1'b1;
          fin_status = ST_OUT;
        end else begin
          // advance to the next table; its read is already issued
          lvl_next = 2'(lvl - 2'd1);
        end
        if (fin) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy             = (state != S_IDLE);
  assign done             = res_valid;
  assign status           = res_status;
  assign physical_address = res_pa;

  a_pa_zero_on_fault: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_status == ST_OK || res_pa == '0))
    else $error("nonzero address reported with a fault status");

  a_no_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == S_IDLE)
    else $error("store written during a walk");

  a_walk_starts_top: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ && $past(state) == S_IDLE) |-> lvl == 2'd3)
    else $error("walk did not start at the top table");

  a_finish_idles: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ && fin) |=> state == S_IDLE && res_valid)
    else $error("walk finished without returning to idle with a result");

endmodule
`default_nettype wire

// ===== rtl/four_level_page_table_walker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Four-level page table walker over an internal store of 64-bit entries.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A table write gives
// no result. A translation reads one table entry per cycle through the
// store's single RAM port, which has registered read data: busy stays high
// while the levels are read (at most four), and done pulses with status and
// physical_address in the cycle after the last read, so a new item may start
// in the done cycle. A walk whose top table lies outside the store reports
// in the next cycle without going busy. The result is valid for that single
// done cycle only; there is no back-pressure, so capture it then. The store
// needs no clearing after reset; reading a never-written entry gives
// arbitrary data. The root table address is written over the APB port at
// byte address 0.
// ----------------------------------------------------------------------------
module four_level_page_table_walker
  import ptw_pkg::*;
#(
  parameter int STORE_WORDS = PTW_STORE_WORDS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output logic      [63:0]        prdata,
  output logic                    pready,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               mode,
  input  wire logic [IDX_W-1:0]   word_index,
  input  wire logic [PTE_W-1:0]   entry_value,
  input  wire logic [VA_W-1:0]    virtual_address,
  output logic                    done,
  output logic [2:0]              status,
  output logic [PA_W-1:0]         physical_address
);

  logic [PA_W-1:0] root_table_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_table_address <= '0;
    end else if (psel && penable && pwrite && paddr == REG_ROOT_ADDR) begin
      root_table_address <= pwdata[PA_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_ROOT_ADDR) ? {12'd0, root_table_address} : 64'd0;

  ptw_walk #(
    .STORE_WORDS (STORE_WORDS)
  ) u_walk (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .mode             (mode),
    .word_index       (word_index),
    .entry_value      (entry_value),
    .virtual_address  (virtual_address),
    .root_frame       (root_table_address[51:12]),
    .busy             (busy),
    .done             (done),
    .status           (status),
    .physical_address (physical_address)
  );

endmodule
`default_nettype wire
